// File: src/tlm_pkg.sv
// Shared types and constants for the text line measure unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package tlm_pkg;

  // Sizes
  localparam int WIN_DEPTH   = 13;
  localparam int TABLE_DEPTH = 95;
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  localparam int DEFAULT_WIDTH_SUM_BITS  = 24;
  localparam int DEFAULT_LINE_COUNT_BITS = 16;

  // Field widths of the result transaction
  localparam int MAX_WIDTH_W  = 24;
  localparam int LINE_COUNT_W = 16;

  // Character codes
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;

  // Request kinds
  localparam logic REQ_TEXT      = 1'b0;
  localparam logic REQ_TABLE_WR  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_TAGS    = 2'd0,
    CFG_BR_TAGS       = 2'd1,
    CFG_NEWLINE_BREAK = 2'd2,
    CFG_QUOTE_AS_AT   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] text_byte;
    logic [6:0] width_index;
    logic [7:0] width_value;
  } in_t;

  typedef struct packed {
    logic [MAX_WIDTH_W-1:0]  max_width;
    logic [LINE_COUNT_W-1:0] num_lines;
    logic                    error;
  } out_t;

  typedef struct packed {
    logic color_tags;
    logic br_tags;
    logic newline_break;
    logic quote_as_at;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic table_wr;  // write width table entry
    logic push;      // append text byte to window
    logic consume;   // process window head
    logic add;       // add table read data to line width
    logic finish;    // load result, clear line state
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic fill_last;  // one slot left in window
    logic fill_zero;  // window empty
    logic need_read;  // head is a measured printable byte
    logic out_free;   // result register can be loaded
  } dp_sts_t;

endpackage

`default_nettype wire

// File: src/tlm_ctrl.sv
// Controller state machine of the text line measure unit.
// Depends on tlm_pkg; drives commands into tlm_dp.
`default_nettype none

module tlm_ctrl
  import tlm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire in_t     in_data,
  output logic         in_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONSUME,
    ST_ADD,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   drain_r, drain_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_TABLE_WR) begin
            cmd.table_wr = 1'b1;
          end else if (in_data.text_byte != 8'h00) begin
            cmd.push = 1'b1;
            if (sts.fill_last) begin
              state_nxt = ST_CONSUME;
            end
          end else begin
            drain_nxt = 1'b1;
            state_nxt = ST_CONSUME;
          end
        end
      end
      ST_CONSUME: begin
        if (drain_r && sts.fill_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.consume = 1'b1;
          if (sts.need_read) begin
            state_nxt = ST_ADD;
          end else if (!drain_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = drain_r ? ST_CONSUME : ST_IDLE;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          drain_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/tlm_dp.sv
// Datapath of the text line measure unit: lookahead window, tag
// decode, width table memory, line sums and result register. Uses tlm_pkg.
`default_nettype none

module tlm_dp
  import tlm_pkg::*;
#(
  parameter int WIDTH_SUM_BITS  = DEFAULT_WIDTH_SUM_BITS,
  parameter int LINE_COUNT_BITS = DEFAULT_LINE_COUNT_BITS
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire dp_cmd_t cmd,
  input  wire in_t     in_data,
  output dp_sts_t      sts,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_t         out_data
);

  localparam int WIN_BITS = WIN_DEPTH * 8;

  localparam logic [47:0] TAG_BLACK = "BLACK>";
  localparam logic [47:0] TAG_WHITE = "WHITE>";
  localparam logic [31:0] TAG_RED   = "RED>";
  localparam logic [39:0] TAG_COLOR = "color";
  localparam logic [31:0] TAG_BR    = "<br>";

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
             (c >= "a" && c <= "f");
  endfunction

  // Window: byte i at [8*i +: 8]; slots at or past fill hold zero.
  logic [WIN_BITS-1:0]        win_r, win_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [WIDTH_SUM_BITS-1:0]  cur_r, cur_nxt, widest_r, widest_nxt, line_max;
  logic [LINE_COUNT_BITS-1:0] lines_r, lines_nxt;
  logic                       err_r, err_nxt;
  logic                       out_valid_r;
  out_t                       out_r;

  logic [7:0]        wb [WIN_DEPTH];
  logic              hit_black, hit_white, hit_red, hit_color, hex_ok;
  logic              color_hit, br_hit, nl_hit, printable;
  logic [FILL_W-1:0] drop_len, drop_eff;
  logic [7:0]        head_sel;
  logic [TBL_AW-1:0] rd_addr;
  logic [WIDTH_SUM_BITS:0] sum;

  logic [7:0] tbl_mem [TABLE_DEPTH];
  logic [7:0] tbl_rd_r;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_wb
    assign wb[i] = win_r[8*i +: 8];
  end

  // Tag decode from fixed window positions
  always_comb begin
    hex_ok = 1'b1;
    for (int i = 6; i < 12; i++) begin
      hex_ok = hex_ok && is_hex(wb[i]);
    end
  end

  assign hit_black = (wb[0] == CHAR_LT) &&
                     ({wb[1], wb[2], wb[3], wb[4], wb[5], wb[6]} == TAG_BLACK);
  assign hit_white = (wb[0] == CHAR_LT) &&
                     ({wb[1], wb[2], wb[3], wb[4], wb[5], wb[6]} == TAG_WHITE);
  assign hit_red   = (wb[0] == CHAR_LT) && ({wb[1], wb[2], wb[3], wb[4]} == TAG_RED);
  assign hit_color = (wb[0] == CHAR_LT) &&
                     ({wb[1], wb[2], wb[3], wb[4], wb[5]} == TAG_COLOR) &&
                     hex_ok && (wb[12] == CHAR_GT);

  assign color_hit = cfg.color_tags && (hit_black || hit_white || hit_red || hit_color);
  assign br_hit    = !color_hit && cfg.br_tags &&
                     ({wb[0], wb[1], wb[2], wb[3]} == TAG_BR);
  assign nl_hit    = !color_hit && !br_hit && cfg.newline_break && (wb[0] == CHAR_NL);
  assign printable = (wb[0] >= CHAR_FIRST) && (wb[0] <= CHAR_LAST);

  always_comb begin
    priority if (color_hit) begin
      if (hit_black || hit_white) begin
        drop_len = FILL_W'(7);
      end else if (hit_red) begin
        drop_len = FILL_W'(5);
      end else begin
        drop_len = FILL_W'(WIN_DEPTH);
      end
    end else if (br_hit) begin
      drop_len = FILL_W'(4);
    end else begin
      drop_len = FILL_W'(1);
    end
  end

  assign drop_eff = (drop_len > fill_r) ? fill_r : drop_len;

  // Quote may borrow the width of '@'
  assign head_sel = (cfg.quote_as_at && wb[0] == CHAR_QUOTE) ? CHAR_AT : wb[0];
  assign rd_addr  = TBL_AW'(head_sel - CHAR_FIRST);

  assign sts.fill_last = (fill_r == FILL_W'(WIN_DEPTH - 1));
  assign sts.fill_zero = (fill_r == '0);
  assign sts.need_read = !color_hit && !br_hit && !nl_hit && printable;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Width table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.table_wr && (in_data.width_index < TBL_AW'(TABLE_DEPTH))) begin
      tbl_mem[in_data.width_index] <= in_data.width_value;
    end
    if (cmd.consume && sts.need_read) begin
      tbl_rd_r <= tbl_mem[rd_addr];
    end
  end

  assign sum      = {1'b0, cur_r} + (WIDTH_SUM_BITS + 1)'(tbl_rd_r);
  assign line_max = (cur_r > widest_r) ? cur_r : widest_r;

  always_comb begin
    win_nxt    = win_r;
    fill_nxt   = fill_r;
    cur_nxt    = cur_r;
    widest_nxt = widest_r;
    lines_nxt  = lines_r;
    err_nxt    = err_r;
    if (cmd.push) begin
      win_nxt  = win_r | (WIN_BITS'(in_data.text_byte) << {fill_r, 3'b000});
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (cmd.consume) begin
      win_nxt  = win_r >> {drop_eff, 3'b000};
      fill_nxt = fill_r - drop_eff;
      if (br_hit || nl_hit) begin
        widest_nxt = line_max;
        cur_nxt    = '0;
        if (lines_r != '1) begin
          lines_nxt = lines_r + LINE_COUNT_BITS'(1);
        end
      end else if (!color_hit && !printable) begin
        err_nxt = 1'b1;
      end
    end
    if (cmd.add) begin
      cur_nxt = sum[WIDTH_SUM_BITS] ? '1 : sum[WIDTH_SUM_BITS-1:0];
    end
    if (cmd.finish) begin
      win_nxt    = '0;
      fill_nxt   = '0;
      cur_nxt    = '0;
      widest_nxt = '0;
      lines_nxt  = LINE_COUNT_BITS'(1);
      err_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      fill_r      <= '0;
      cur_r       <= '0;
      widest_r    <= '0;
      lines_r     <= LINE_COUNT_BITS'(1);
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r    <= win_nxt;
      fill_r   <= fill_nxt;
      cur_r    <= cur_nxt;
      widest_r <= widest_nxt;
      lines_r  <= lines_nxt;
      err_r    <= err_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.max_width <= MAX_WIDTH_W'(line_max);
      out_r.num_lines <= LINE_COUNT_W'(lines_r);
      out_r.error     <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: src/text_width_line_measure_unit.sv
// Top level of the text line measure unit: configuration registers,
// controller and datapath. Depends on tlm_pkg, tlm_ctrl and tlm_dp.
//
//   channel  dir  handshake              payload
//   in_*     in   in_valid / in_stall    in_t  (req_type, text_byte, width_index, width_value)
//   out_*    out  out_valid / out_stall  out_t (max_width, num_lines, error)
//   cfg_*    in   cfg_we                 cfg_index, cfg_wdata
//
// A table write or a byte that does not fill the window leaves the controller idle.
// A byte that fills the 13-byte window is followed by a consume step, and by an add
// step when the head is a measured character (width table read is registered).
// The zero byte drains the window head by head, then finishes.
// Synchronous active-low reset clears control, window and sums; the width
// table is undefined until written. A stalled result holds in the output
// register while the next string is accepted; only finishing waits on it.
`default_nettype none

module text_width_line_measure_unit
  import tlm_pkg::*;
#(
  parameter int WIDTH_SUM_BITS  = DEFAULT_WIDTH_SUM_BITS,
  parameter int LINE_COUNT_BITS = DEFAULT_LINE_COUNT_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input transaction
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  // result transaction
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_wdata
);

  cfg_t    cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Config register file, write only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_COLOR_TAGS:    cfg_r.color_tags    <= cfg_wdata;
        CFG_BR_TAGS:       cfg_r.br_tags       <= cfg_wdata;
        CFG_NEWLINE_BREAK: cfg_r.newline_break <= cfg_wdata;
        CFG_QUOTE_AS_AT:   cfg_r.quote_as_at   <= cfg_wdata;
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  tlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlm_dp #(
    .WIDTH_SUM_BITS  (WIDTH_SUM_BITS),
    .LINE_COUNT_BITS (LINE_COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // At most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.table_wr, cmd.push, cmd.consume, cmd.add, cmd.finish}))
    else $error("more than one datapath command");

  // Head is only processed with a nonempty window
  a_consume_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.consume |-> !sts.fill_zero)
    else $error("consume on empty window");

  // Add only follows a table read
  a_add_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add |-> $past(cmd.consume && sts.need_read))
    else $error("add without table read");

  // Finishing presents a result
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finish did not load result");

endmodule

`default_nettype wire

// File: sim/tlm_checker.sv
// Scoreboard for the text line measure unit: watches the input, result and
// configuration ports, predicts each line report and compares it.
// Depends on tlm_pkg for the transaction and register types.
module tlm_checker
  import tlm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  output int                   fail_count,
  output int                   reports_due,
  output int                   reports_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MAX_WIDTH_W-1:0]  WIDTH_CAP = '1;
  localparam logic [LINE_COUNT_W-1:0] LINES_CAP = '1;

  cfg_t                    mode;
  logic [7:0]              adv_table [TABLE_DEPTH];
  logic [7:0]              window [WIN_DEPTH];
  int unsigned             held;
  logic [MAX_WIDTH_W-1:0]  line_sum;
  logic [MAX_WIDTH_W-1:0]  widest_sum;
  logic [LINE_COUNT_W-1:0] line_total;
  logic                    bad_byte;
  out_t                    awaited_reports [$];
  int                      fails = 0;
  int                      checked = 0;

  // bytes past the filled part of the window read as zero
  function automatic logic [7:0] peek(int unsigned i);
    return (i < held) ? window[i] : 8'h00;
  endfunction

  function automatic bit window_holds(int unsigned start, string pat);
    int i;
    for (i = 0; i < pat.len(); i++)
      if (peek(start + i) != pat[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit hex_digit(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic int unsigned color_tag_len();
    int i;
    if (peek(0) != CHAR_LT) return 0;
    if (window_holds(1, "BLACK>") || window_holds(1, "WHITE>")) return 7;
    if (window_holds(1, "RED>")) return 5;
    if (!window_holds(1, "color")) return 0;
    for (i = 6; i < 12; i++)
      if (!hex_digit(peek(i))) return 0;
    return (peek(12) == CHAR_GT) ? 13 : 0;
  endfunction

  function automatic void shift_out(int unsigned k);
    int unsigned i;
    if (k > held) k = held;
    for (i = 0; i < WIN_DEPTH; i++)
      window[i] = (i + k < held) ? window[i + k] : 8'h00;
    held -= k;
  endfunction

  function automatic void break_line();
    if (line_sum > widest_sum) widest_sum = line_sum;
    line_sum = '0;
    if (line_total != LINES_CAP) line_total++;
  endfunction

  function automatic void take_head();
    logic [7:0]             c;
    int unsigned            k;
    logic [MAX_WIDTH_W:0]   sum;
    c = peek(0);
    k = color_tag_len();
    if (mode.color_tags && k != 0) begin
      shift_out(k);
      return;
    end
    if (mode.br_tags && window_holds(0, "<br>")) begin
      shift_out(4);
      break_line();
      return;
    end
    if (mode.newline_break && c == CHAR_NL) begin
      shift_out(1);
      break_line();
      return;
    end
    if (c < CHAR_FIRST || c > CHAR_LAST) begin
      bad_byte = 1'b1;
    end else begin
      if (mode.quote_as_at && c == CHAR_QUOTE) c = CHAR_AT;
      sum = line_sum + adv_table[c - CHAR_FIRST];
      line_sum = (sum > WIDTH_CAP) ? WIDTH_CAP : sum[MAX_WIDTH_W-1:0];
    end
    shift_out(1);
  endfunction

  function automatic void clear_string();
    int i;
    for (i = 0; i < WIN_DEPTH; i++) window[i] = 8'h00;
    held       = 0;
    line_sum   = '0;
    widest_sum = '0;
    line_total = LINE_COUNT_W'(1);
    bad_byte   = 1'b0;
  endfunction

  function automatic void absorb_item(in_t it);
    out_t rep;
    if (it.req_type == REQ_TABLE_WR) begin
      if (it.width_index < TABLE_DEPTH) adv_table[it.width_index] = it.width_value;
      return;
    end
    if (it.text_byte != 8'h00) begin
      if (held < WIN_DEPTH) begin
        window[held] = it.text_byte;
        held++;
      end
      if (held >= WIN_DEPTH) take_head();
      return;
    end
    // terminator: drain the window, then report
    while (held > 0) take_head();
    if (line_sum > widest_sum) widest_sum = line_sum;
    rep.max_width = widest_sum;
    rep.num_lines = line_total;
    rep.error     = bad_byte;
    awaited_reports.push_back(rep);
    clear_string();
  endfunction

  function automatic void check_report(out_t got);
    out_t want;
    if (awaited_reports.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected result transaction: width %0d lines %0d error %0b",
                 got.max_width, got.num_lines, got.error);
      return;
    end
    want = awaited_reports.pop_front();
    checked++;
    if (got.max_width !== want.max_width || got.num_lines !== want.num_lines ||
        got.error !== want.error) begin
      fails++;
      if (fails <= 10)
        $display("mismatch: expected width %0d lines %0d error %0b, %s",
                 want.max_width, want.num_lines, want.error,
                 $sformatf("got width %0d lines %0d error %0b",
                           got.max_width, got.num_lines, got.error));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode = '0;
      clear_string();
      awaited_reports.delete();
    end else begin
      // a result always belongs to an earlier terminator, so check first
      if (out_valid && !out_stall) check_report(out_data);
      if (in_valid && !in_stall) absorb_item(in_data);
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          CFG_COLOR_TAGS:    mode.color_tags    = cfg_wdata;
          CFG_BR_TAGS:       mode.br_tags       = cfg_wdata;
          CFG_NEWLINE_BREAK: mode.newline_break = cfg_wdata;
          CFG_QUOTE_AS_AT:   mode.quote_as_at   = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count      <= fails;
    reports_due     <= awaited_reports.size();
    reports_checked <= checked;
  end

endmodule

// File: sim/text_width_line_measure_unit_tb.sv
// Testbench top for the text line measure unit: clock, reset, stimulus and
// verdict. Depends on tlm_pkg, text_width_line_measure_unit and tlm_checker.
module text_width_line_measure_unit_tb
  import tlm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Limit for ~1350 transactions under the heaviest idling, with a wide margin.
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS   = 195;   // six random phases plus directed, ~1350 items
  localparam int RANDOM_PHASES = 6;

  typedef logic [7:0] byte_q_t [$];

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_t                  in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_wdata = 1'b0;
  wire logic            in_stall;
  wire logic            out_valid;
  wire out_t            out_data;

  int   fail_count;
  int   reports_due;
  int   reports_checked;
  int   cycle_count    = 0;
  int   send_gap_pct   = 0;   // chance the sender idles before a transaction
  int   recv_hold_pct  = 0;   // chance the receiver stalls in a cycle
  int   sent_items     = 0;
  int   settings_used  = 0;
  in_t  stim_q [$];

  text_width_line_measure_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tlm_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .reports_due     (reports_due),
    .reports_checked (reports_checked)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still awaited", cycle_count, reports_due);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle on the falling edge.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_hold_pct);
  end

  // ---- stimulus builders ---------------------------------------------------

  // Text transaction; the table fields are don't-care and get random filler.
  task automatic push_byte(input logic [7:0] b);
    in_t it;
    it.req_type    = REQ_TEXT;
    it.text_byte   = b;
    it.width_index = 7'($urandom_range(127));
    it.width_value = 8'($urandom_range(255));
    stim_q.push_back(it);
  endtask

  // Width table write; indexes above 94 must be dropped by the block.
  task automatic push_table_write(input int idx, input logic [7:0] val);
    in_t it;
    it.req_type    = REQ_TABLE_WR;
    it.text_byte   = 8'($urandom_range(255));
    it.width_index = idx[6:0];
    it.width_value = val;
    stim_q.push_back(it);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Tag-shaped byte sequences: kinds 0..3 are valid color tags, 4 is a
  // color tag with one byte corrupted, 5 is <br>, 6 a near miss of <br>.
  task automatic make_tag(input int kind, output byte_q_t tb);
    string hexset;
    string s;
    int    i;
    int    pos;
    hexset = "0123456789ABCDEFabcdef";
    tb.delete();
    case (kind)
      0: s = "<BLACK>";
      1: s = "<WHITE>";
      2: s = "<RED>";
      5: s = "<br>";
      6: s = $urandom_range(1) ? "<bR>" : "<br ";
      default: s = "<color";
    endcase
    for (i = 0; i < s.len(); i++) tb.push_back(s[i]);
    if (kind == 3 || kind == 4) begin
      for (i = 0; i < 6; i++) tb.push_back(hexset[$urandom_range(21)]);
      tb.push_back(CHAR_GT);
      if (kind == 4) begin
        pos = $urandom_range(1, 12);
        tb[pos] = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
      end
    end
  endtask

  // One zero-terminated string of random tokens. A mix of well-formed tags and
  // breaks so the lookahead path gets exercised, plus noise, bad bytes,
  // mid-string table writes and now and then a tag cut off by the end.
  task automatic gen_text_string();
    byte_q_t tok;
    int      ntok;
    int      r;
    int      i;
    int      cut;
    ntok = $urandom_range(0, 14);
    repeat (ntok) begin
      r = $urandom_range(99);
      if (r < 30) begin
        push_byte(8'($urandom_range(CHAR_FIRST, CHAR_LAST)));
      end else if (r < 38) begin
        push_byte(CHAR_QUOTE);
      end else if (r < 65) begin
        make_tag(r < 50 ? $urandom_range(3) : (r < 57 ? 4 : 5), tok);
        foreach (tok[i]) push_byte(tok[i]);
      end else if (r < 69) begin
        make_tag(6, tok);
        foreach (tok[i]) push_byte(tok[i]);
      end else if (r < 77) begin
        push_byte(CHAR_NL);
      end else if (r < 83) begin
        push_byte($urandom_range(1) ? 8'($urandom_range(1, 31)) :
                                      8'($urandom_range(127, 255)));
      end else if (r < 90) begin
        push_table_write($urandom_range(127), 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(CHAR_FIRST, CHAR_LAST)));
      end
    end
    // tag cut short by the terminator must be measured byte by byte
    if ($urandom_range(99) < 20) begin
      make_tag($urandom_range(5), tok);
      cut = $urandom_range(1, tok.size() - 1);
      for (i = 0; i < cut; i++) push_byte(tok[i]);
    end
    push_byte(8'h00);
  endtask

  // ---- drivers -------------------------------------------------------------

  // Drive one input transaction at the falling edge and hold it until it is
  // taken. Valid is only lowered for a chosen gap, so back-to-back
  // transactions never see a lower-then-raise within one time step.
  task automatic send_item(input in_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic drain_stim();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Every phase ends in a terminator, so once its report is out the block
  // has nothing in flight.
  task automatic wait_idle();
    while (reports_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All four registers are rewritten at every phase boundary.
  task automatic set_mode(input cfg_t m);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_COLOR_TAGS;    cfg_wdata <= m.color_tags;
    @(negedge clk);
    cfg_index <= CFG_BR_TAGS;       cfg_wdata <= m.br_tags;
    @(negedge clk);
    cfg_index <= CFG_NEWLINE_BREAK; cfg_wdata <= m.newline_break;
    @(negedge clk);
    cfg_index <= CFG_QUOTE_AS_AT;   cfg_wdata <= m.quote_as_at;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic set_idling(input int regime);
    case (regime)
      0:       begin send_gap_pct = 21; recv_hold_pct = 83; end
      1:       begin send_gap_pct = 83; recv_hold_pct = 21; end
      default: begin send_gap_pct = 0;  recv_hold_pct = 0;  end
    endcase
  endtask

  // ---- main sequence -------------------------------------------------------

  initial begin
    cfg_t phase_mode [RANDOM_PHASES];
    int   p;
    int   i;

    // extremes first, then mixed settings
    phase_mode[0] = '0;
    phase_mode[1] = '1;
    phase_mode[2] = cfg_t'($urandom_range(15));
    phase_mode[3] = cfg_t'(4'b1010);
    phase_mode[4] = cfg_t'(4'b0101);
    phase_mode[5] = cfg_t'($urandom_range(15));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all features on, full table load (no entry is ever read
    // unwritten), table extremes and out-of-range writes, then strings that
    // hit a color tag, quote remap, bad bytes, <br>, newline, an empty
    // string and a tag cut by the terminator.
    set_idling(0);
    set_mode('1);
    for (i = 0; i < TABLE_DEPTH; i++) push_table_write(i, 8'($urandom_range(255)));
    push_table_write(0, 8'h00);
    push_table_write(94, 8'hFF);
    push_table_write(95, 8'($urandom_range(255)));
    push_table_write(127, 8'($urandom_range(255)));
    push_text("<RED>\"~");
    push_byte(8'h01);
    push_text("<br>");
    push_byte(CHAR_NL);
    push_byte(8'hFF);
    push_byte(8'h7F);
    push_byte(8'h00);
    push_byte(8'h00);
    push_text("<BL");
    push_byte(8'h00);
    drain_stim();
    wait_idle();

    // Random phases: two per idling regime.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      set_idling(p / 2);
      set_mode(phase_mode[p]);
      while (stim_q.size() < PHASE_ITEMS) gen_text_string();
      drain_stim();
      wait_idle();
    end

    $display("%0d input transactions over %0d register settings, %0d line reports compared",
             sent_items, settings_used, reports_checked);
    $display("covered tags, breaks, quote remap, bad bytes, cut tags, table writes mid-string");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
